// ----- hdl/cdsw_pkg.sv -----
// ----------------------------------------------------------------------------
// cdsw_pkg
// Shared types, constants and calendar tables for the date shifter.
// ----------------------------------------------------------------------------
package cdsw_pkg;

  localparam int unsigned YearW      = 14;
  localparam int unsigned MonW       = 4;
  localparam int unsigned DomW       = 5;
  localparam int unsigned RemW       = 7;   // year mod 100
  localparam int unsigned CentW      = 8;   // year div 100
  localparam int unsigned SerW       = 22;  // day serial up to year 9999
  localparam int unsigned Q7W        = 19;

  localparam logic [YearW-1:0] MaxYear    = YearW'(9999);
  localparam logic [YearW-1:0] MinYearRst = YearW'(1900);

  // floor(y / 100) = (y * 5243) >> 19, exact for 14-bit y
  localparam int unsigned RecipHundred = 5243;
  localparam int unsigned RecipHundSh  = 19;
  // floor(s / 7) is (s * 599186) >> 22 or one less
  localparam int unsigned RecipSeven   = 599186;
  localparam int unsigned RecipSevenSh = 22;

  // serial of the reference Sunday, 23 Feb 2020
  localparam int unsigned RefSerial = 2020 * 365 + 2023 / 4 - 2119 / 100 + 2419 / 400
                                      + 31 + 23;
  localparam int unsigned RefMod    = RefSerial % 7;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_DATE = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  // one request handed from the front end to the back end (day travels apart)
  typedef struct packed {
    logic             bad;
    logic [MonW-1:0]  mon;
    logic [YearW-1:0] yr;
    logic [RemW-1:0]  rem100;
    logic [CentW-1:0] cent;
  } job_t;

  function automatic logic [DomW-1:0] days_in(input logic [MonW-1:0] m, input logic leap);
    logic [DomW-1:0] d;
    case (m)
      4'd2:                      d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

  // days in the year before the first of month m
  function automatic logic [8:0] cum_days(input logic [MonW-1:0] m, input logic leap);
    logic [8:0] c;
    case (m)
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    if (leap && (m > 4'd2)) c = c + 9'd1;
    return c;
  endfunction

  function automatic logic is_leap(input logic [1:0] y_lo, input logic [RemW-1:0] rem100,
                                   input logic [1:0] cent_lo);
    return (y_lo == 2'd0) && ((rem100 != '0) || (cent_lo == 2'd0));
  endfunction

endpackage

// ----- hdl/cdsw_front.sv -----
// ----------------------------------------------------------------------------
// cdsw_front
// Accepts a request, splits the year by 100 and checks the date.
// ----------------------------------------------------------------------------
module cdsw_front #(
  parameter int unsigned OFFSET_BITS = 17
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [cdsw_pkg::YearW-1:0]        min_year_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [cdsw_pkg::DomW-1:0]         in_day_i,
  input  logic [cdsw_pkg::MonW-1:0]         in_month_i,
  input  logic [cdsw_pkg::YearW-1:0]        in_year_i,
  input  logic signed [OFFSET_BITS-1:0]     offset_days_i,
  input  logic                              q_full_i,
  output logic                              push_o,
  output cdsw_pkg::job_t                    push_job_o,
  output logic signed [OFFSET_BITS:0]       push_day_o
);

  localparam int unsigned DayW  = OFFSET_BITS + 1;
  localparam int unsigned ProdW = cdsw_pkg::YearW + 13;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_CHK  = 3'b100
  } fstate_e;

  fstate_e state_q, state_d;

  logic [cdsw_pkg::DomW-1:0]  day_q;
  logic [cdsw_pkg::MonW-1:0]  mon_q;
  logic [cdsw_pkg::YearW-1:0] yr_q;
  logic signed [OFFSET_BITS-1:0] off_q;
  logic [cdsw_pkg::CentW-1:0] cent_q;

  logic                       accept;
  logic [ProdW-1:0]           prod;
  logic [cdsw_pkg::YearW-1:0] rem_full;
  logic [cdsw_pkg::RemW-1:0]  rem100;
  logic                       leap;
  logic [cdsw_pkg::DomW-1:0]  dim;
  logic                       bad;

  assign in_stall_o = (state_q != F_IDLE);
  assign accept     = in_valid_i && (state_q == F_IDLE);

  // century by reciprocal multiply
  assign prod = ProdW'(yr_q) * ProdW'(cdsw_pkg::RecipHundred);

  // remainder, leap and date check
  assign rem_full = yr_q - (cdsw_pkg::YearW'(cent_q) * cdsw_pkg::YearW'(100));
  assign rem100   = rem_full[cdsw_pkg::RemW-1:0];
  assign leap     = cdsw_pkg::is_leap(yr_q[1:0], rem100, cent_q[1:0]);
  assign dim      = cdsw_pkg::days_in(mon_q, leap);
  assign bad      = (mon_q == '0) || (mon_q > 4'd12) || (yr_q > cdsw_pkg::MaxYear) ||
                    (yr_q < min_year_i) || (day_q == '0) || (day_q > dim);

  assign push_o            = (state_q == F_CHK) && !q_full_i;
  assign push_job_o.bad    = bad;
  assign push_job_o.mon    = mon_q;
  assign push_job_o.yr     = yr_q;
  assign push_job_o.rem100 = rem100;
  assign push_job_o.cent   = cent_q;
  assign push_day_o = $signed({{(DayW-cdsw_pkg::DomW){1'b0}}, day_q}) +
                      $signed({off_q[OFFSET_BITS-1], off_q});

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (accept) state_d = F_MUL;
      F_MUL:  state_d = F_CHK;
      F_CHK:  if (!q_full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // request payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      day_q <= in_day_i;
      mon_q <= in_month_i;
      yr_q  <= in_year_i;
      off_q <= offset_days_i;
    end
    if (state_q == F_MUL) begin
      cent_q <= prod[cdsw_pkg::RecipHundSh +: cdsw_pkg::CentW];
    end
  end

endmodule

// ----- hdl/cdsw_queue.sv -----
// ----------------------------------------------------------------------------
// cdsw_queue
// Two-entry FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module cdsw_queue #(
  parameter int unsigned DAY_BITS = 18
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  cdsw_pkg::job_t              push_job_i,
  input  logic signed [DAY_BITS-1:0]  push_day_i,
  output logic                        full_o,
  input  logic                        pop_i,
  output logic                        empty_o,
  output cdsw_pkg::job_t              head_job_o,
  output logic signed [DAY_BITS-1:0]  head_day_o
);

  cdsw_pkg::job_t              job_q [2];
  logic signed [DAY_BITS-1:0]  day_q [2];
  logic                        wr_ptr_q, rd_ptr_q;
  logic [1:0]                  cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign head_job_o = job_q[rd_ptr_q];
  assign head_day_o = day_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      job_q[wr_ptr_q] <= push_job_i;
      day_q[wr_ptr_q] <= push_day_i;
    end
  end

endmodule

// ----- hdl/cdsw_back.sv -----
// ----------------------------------------------------------------------------
// cdsw_back
// Steps the date one month per cycle, then derives the weekday.
// ----------------------------------------------------------------------------
module cdsw_back #(
  parameter int unsigned DAY_BITS = 18
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [cdsw_pkg::YearW-1:0]  min_year_i,
  input  logic                        empty_i,
  input  cdsw_pkg::job_t              head_job_i,
  input  logic signed [DAY_BITS-1:0]  head_day_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [cdsw_pkg::DomW-1:0]   out_day_o,
  output logic [cdsw_pkg::MonW-1:0]   out_month_o,
  output logic [cdsw_pkg::YearW-1:0]  out_year_o,
  output logic [2:0]                  weekday_o,
  output logic [1:0]                  status_o
);

  localparam int unsigned SerW = cdsw_pkg::SerW;
  localparam int unsigned MulW = SerW + 20;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_STEP = 5'b00010,
    B_SER  = 5'b00100,
    B_MOD  = 5'b01000,
    B_WDAY = 5'b10000
  } bstate_e;

  bstate_e state_q, state_d;
  cdsw_pkg::status_e st_q, st_d;
  logic signed [DAY_BITS-1:0]  day_q, day_d;
  logic [cdsw_pkg::MonW-1:0]   mon_q, mon_d;
  logic [cdsw_pkg::YearW-1:0]  yr_q, yr_d;
  logic [cdsw_pkg::RemW-1:0]   rem_q, rem_d;
  logic [cdsw_pkg::CentW-1:0]  cent_q, cent_d;
  logic [SerW-1:0]             ser_q, ser_d;
  logic [cdsw_pkg::Q7W-1:0]    q7_q, q7_d;
  logic                        ov_q, ov_d;
  logic [cdsw_pkg::DomW-1:0]   od_q, od_d;
  logic [cdsw_pkg::MonW-1:0]   om_q, om_d;
  logic [cdsw_pkg::YearW-1:0]  oy_q, oy_d;
  logic [2:0]                  ow_q, ow_d;
  logic [1:0]                  os_q, os_d;

  logic                        leap, rnz, slot_free;
  logic [cdsw_pkg::DomW-1:0]   dim_cur, dim_prev;
  logic signed [DAY_BITS-1:0]  dim_cur_s, dim_prev_s;
  logic [SerW-1:0]             y22, ser_c;
  logic [MulW-1:0]             prod7;
  logic [SerW-1:0]             r7_full;
  logic [3:0]                  r7, wd;

  assign out_valid_o = ov_q;
  assign out_day_o   = od_q;
  assign out_month_o = om_q;
  assign out_year_o  = oy_q;
  assign weekday_o   = ow_q;
  assign status_o    = os_q;

  assign slot_free = !ov_q || !out_stall_i;
  assign pop_o     = (state_q == B_IDLE) && !empty_i;

  // month lengths around the current month
  assign rnz        = (rem_q != '0);
  assign leap       = cdsw_pkg::is_leap(yr_q[1:0], rem_q, cent_q[1:0]);
  assign dim_cur    = cdsw_pkg::days_in(mon_q, leap);
  assign dim_prev   = (mon_q == 4'd1) ? 5'd31 : cdsw_pkg::days_in(mon_q - 4'd1, leap);
  assign dim_cur_s  = $signed({{(DAY_BITS-cdsw_pkg::DomW){1'b0}}, dim_cur});
  assign dim_prev_s = $signed({{(DAY_BITS-cdsw_pkg::DomW){1'b0}}, dim_prev});

  // day serial from year 0
  assign y22   = SerW'(yr_q);
  assign ser_c = y22 * SerW'(365) + ((y22 + SerW'(3)) >> 2) - SerW'(cent_q) - SerW'(rnz)
               + SerW'(cent_q >> 2) + SerW'(rnz || (cent_q[1:0] != 2'd0))
               + SerW'(cdsw_pkg::cum_days(mon_q, leap)) + SerW'(day_q[cdsw_pkg::DomW-1:0]);

  // serial mod 7
  assign prod7   = MulW'(ser_q) * MulW'(cdsw_pkg::RecipSeven);
  assign r7_full = ser_q - (SerW'(q7_q) * SerW'(7));
  assign r7      = (r7_full[3:0] >= 4'd7) ? (r7_full[3:0] - 4'd7) : r7_full[3:0];
  assign wd      = ((r7 + 4'(7 - cdsw_pkg::RefMod)) >= 4'd7) ?
                   (r7 + 4'(7 - cdsw_pkg::RefMod) - 4'd7) : (r7 + 4'(7 - cdsw_pkg::RefMod));

  // sequencer
  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    day_d   = day_q;
    mon_d   = mon_q;
    yr_d    = yr_q;
    rem_d   = rem_q;
    cent_d  = cent_q;
    ser_d   = ser_q;
    q7_d    = q7_q;
    ov_d    = ov_q && out_stall_i;
    od_d    = od_q;
    om_d    = om_q;
    oy_d    = oy_q;
    ow_d    = ow_q;
    os_d    = os_q;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          day_d  = head_day_i;
          mon_d  = head_job_i.mon;
          yr_d   = head_job_i.yr;
          rem_d  = head_job_i.rem100;
          cent_d = head_job_i.cent;
          if (head_job_i.bad) begin
            st_d    = cdsw_pkg::ST_BAD_DATE;
            state_d = B_WDAY;
          end else begin
            st_d    = cdsw_pkg::ST_OK;
            state_d = B_STEP;
          end
        end
      end
      B_STEP: begin
        if (day_q > dim_cur_s) begin
          day_d = day_q - dim_cur_s;
          if (mon_q == 4'd12) begin
            if (yr_q == cdsw_pkg::MaxYear) begin
              st_d    = cdsw_pkg::ST_RANGE;
              state_d = B_WDAY;
            end
            mon_d = 4'd1;
            yr_d  = yr_q + 1'b1;
            if (rem_q == 7'd99) begin
              rem_d  = '0;
              cent_d = cent_q + 1'b1;
            end else begin
              rem_d = rem_q + 1'b1;
            end
          end else begin
            mon_d = mon_q + 4'd1;
          end
        end else if (day_q < $signed(DAY_BITS'(1))) begin
          day_d = day_q + dim_prev_s;
          if (mon_q == 4'd1) begin
            // stepping below the lowest year ends in an out-of-range result
            if ((yr_q == min_year_i) || (yr_q == '0)) begin
              st_d    = cdsw_pkg::ST_RANGE;
              state_d = B_WDAY;
            end
            mon_d = 4'd12;
            yr_d  = yr_q - 1'b1;
            if (rem_q == '0) begin
              rem_d  = 7'd99;
              cent_d = cent_q - 1'b1;
            end else begin
              rem_d = rem_q - 1'b1;
            end
          end else begin
            mon_d = mon_q - 4'd1;
          end
        end else begin
          state_d = B_SER;
        end
      end
      B_SER: begin
        ser_d   = ser_c;
        state_d = B_MOD;
      end
      B_MOD: begin
        q7_d    = prod7[cdsw_pkg::RecipSevenSh +: cdsw_pkg::Q7W];
        state_d = B_WDAY;
      end
      B_WDAY: begin
        if (slot_free) begin
          ov_d = 1'b1;
          os_d = st_q;
          if (st_q == cdsw_pkg::ST_OK) begin
            od_d = day_q[cdsw_pkg::DomW-1:0];
            om_d = mon_q;
            oy_d = yr_q;
            ow_d = wd[2:0];
          end else begin
            od_d = '0;
            om_d = '0;
            oy_d = '0;
            ow_d = '0;
          end
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q   <= st_d;
    day_q  <= day_d;
    mon_q  <= mon_d;
    yr_q   <= yr_d;
    rem_q  <= rem_d;
    cent_q <= cent_d;
    ser_q  <= ser_d;
    q7_q   <= q7_d;
    od_q   <= od_d;
    om_q   <= om_d;
    oy_q   <= oy_d;
    ow_q   <= ow_d;
    os_q   <= os_d;
  end

endmodule

// ----- hdl/calendar_date_shift_weekday.sv -----
// ----------------------------------------------------------------------------
// calendar_date_shift_weekday
// Adds a signed day count to a Gregorian date and reports the weekday.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries a date and a signed day
//   offset; output channel (out_valid_o / out_stall_i) returns the shifted
//   date, weekday (0 Sunday) and status. One result per request, in order.
//   min_year is written through cfg_we_i / cfg_wdata_i while the block is
//   idle; the user must keep to this, as the block does not enforce it.
// Sequence: the front end accepts, splits the century and checks; the back
//   end steps one month per cycle, then forms the serial, mod 7 and weekday
//   into the output register; about 2160 months for a 65535-day offset.
// Throughput: one request per back-end pass, set by month stepping; the front
//   end takes a request once the last is queued; two may wait in the queue.
// Reset: min_year returns to 1900, queue and output register empty.
// Stall: a stalled result holds; the back end waits with the next finished
//   result until the output register frees, and the front end stalls once
//   the queue is full.
// ----------------------------------------------------------------------------
module calendar_date_shift_weekday #(
  parameter int unsigned OFFSET_BITS = 17
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cdsw_pkg::YearW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [cdsw_pkg::DomW-1:0]     in_day_i,
  input  logic [cdsw_pkg::MonW-1:0]     in_month_i,
  input  logic [cdsw_pkg::YearW-1:0]    in_year_i,
  input  logic signed [OFFSET_BITS-1:0] offset_days_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cdsw_pkg::DomW-1:0]     out_day_o,
  output logic [cdsw_pkg::MonW-1:0]     out_month_o,
  output logic [cdsw_pkg::YearW-1:0]    out_year_o,
  output logic [2:0]                    weekday_o,
  output logic [1:0]                    status_o
);

  localparam int unsigned DayW = OFFSET_BITS + 1;

  logic [cdsw_pkg::YearW-1:0] min_year_q;
  logic                       push, full, pop, empty;
  cdsw_pkg::job_t             push_job, head_job;
  logic signed [DayW-1:0]     push_day, head_day;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_year_q <= cdsw_pkg::MinYearRst;
    end else if (cfg_we_i) begin
      min_year_q <= cfg_wdata_i;
    end
  end

  cdsw_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .min_year_i   (min_year_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_day_i     (in_day_i),
    .in_month_i   (in_month_i),
    .in_year_i    (in_year_i),
    .offset_days_i(offset_days_i),
    .q_full_i     (full),
    .push_o       (push),
    .push_job_o   (push_job),
    .push_day_o   (push_day)
  );

  cdsw_queue #(.DAY_BITS(DayW)) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_job_i(push_job),
    .push_day_i(push_day),
    .full_o    (full),
    .pop_i     (pop),
    .empty_o   (empty),
    .head_job_o(head_job),
    .head_day_o(head_day)
  );

  cdsw_back #(.DAY_BITS(DayW)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .min_year_i (min_year_q),
    .empty_i    (empty),
    .head_job_i (head_job),
    .head_day_i (head_day),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_day_o  (out_day_o),
    .out_month_o(out_month_o),
    .out_year_o (out_year_o),
    .weekday_o  (weekday_o),
    .status_o   (status_o)
  );

endmodule

// ----- hdl/cdsw_checker.sv -----
// ----------------------------------------------------------------------------
// cdsw_checker
// Port-level checks on the result channel of the date shifter.
// ----------------------------------------------------------------------------
module cdsw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [4:0]  out_day_o,
  input logic [3:0]  out_month_o,
  input logic [13:0] out_year_o,
  input logic [2:0]  weekday_o,
  input logic [1:0]  status_o
);

  // error results carry an all-zero date
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != cdsw_pkg::ST_OK) |->
      (out_day_o == '0) && (out_month_o == '0) && (out_year_o == '0) && (weekday_o == '0))
    else $error("error result with nonzero date");

  // good results lie within calendar bounds
  a_ok_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == cdsw_pkg::ST_OK) |->
      (out_day_o != '0) && (out_month_o != '0) && (out_month_o <= 4'd12) &&
      (weekday_o <= 3'd6) && (out_year_o <= cdsw_pkg::MaxYear))
    else $error("ok result outside calendar");

  // status code is one of the three defined
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == cdsw_pkg::ST_OK) || (status_o == cdsw_pkg::ST_BAD_DATE) ||
                    (status_o == cdsw_pkg::ST_RANGE))
    else $error("undefined status");

  // a stalled result stays valid with status and day unchanged
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(out_day_o))
    else $error("stalled result changed");

endmodule

bind calendar_date_shift_weekday cdsw_checker u_cdsw_checker (.*);
